FILE: sv/bdrm_pkg.sv
`timescale 1ns / 1ps

package bdrm_pkg;

  // Fixed field widths of the channels.
  localparam int WORD_W  = 64;
  localparam int IDX_W   = 16;
  localparam int DIST_W  = 9;
  localparam int CNT_W   = 2;
  localparam int CFG_W   = 8;
  localparam int ADDR_W  = 4;
  localparam int APB_W   = 32;
  localparam int PROD_W  = 18;

  // A distance of 257 stands for "no candidate yet".
  localparam logic [DIST_W-1:0] DIST_NONE = 9'd257;
  localparam logic [CNT_W-1:0]  CNT_ZERO  = 2'd0;
  localparam logic [CNT_W-1:0]  CNT_TWO   = 2'd2;

  // Configuration register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_RATIO_NUM = 2'd0;
  localparam logic [1:0] REG_RATIO_DEN = 2'd1;
  localparam logic [1:0] REG_ABS_NUM   = 2'd2;
  localparam logic [1:0] REG_ABS_DEN   = 2'd3;

  localparam logic [CFG_W-1:0] RATIO_NUM_RST = 8'd4;
  localparam logic [CFG_W-1:0] RATIO_DEN_RST = 8'd5;
  localparam logic [CFG_W-1:0] ABS_NUM_RST   = 8'd3;
  localparam logic [CFG_W-1:0] ABS_DEN_RST   = 8'd10;

  typedef struct packed {
    logic [WORD_W-1:0] query_w0;
    logic [WORD_W-1:0] query_w1;
    logic [WORD_W-1:0] query_w2;
    logic [WORD_W-1:0] query_w3;
    logic [WORD_W-1:0] cand_w0;
    logic [WORD_W-1:0] cand_w1;
    logic [WORD_W-1:0] cand_w2;
    logic [WORD_W-1:0] cand_w3;
    logic [IDX_W-1:0]  cand_index;
    logic              last_cand;
  } in_item_t;

  typedef struct packed {
    logic              matched;
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
    logic [DIST_W-1:0] second_distance;
    logic [CNT_W-1:0]  cand_count;
  } out_item_t;

  // One candidate after the distance stage.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } dist_beat_t;

  typedef struct packed {
    logic [CFG_W-1:0] ratio_num;
    logic [CFG_W-1:0] ratio_den;
    logic [CFG_W-1:0] abs_num;
    logic [CFG_W-1:0] abs_den;
  } cfg_regs_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: sv/bdrm_cfg.sv
`timescale 1ns / 1ps

module bdrm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdrm_pkg::ADDR_W-1:0] paddr,
  input  logic [bdrm_pkg::APB_W-1:0]  pwdata,
  output logic [bdrm_pkg::APB_W-1:0]  prdata,
  output logic                        pready,
  output bdrm_pkg::cfg_regs_t         cfg
);
  import bdrm_pkg::*;

  cfg_regs_t   cfg_r;
  logic        wr_en;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio_num <= RATIO_NUM_RST;
      cfg_r.ratio_den <= RATIO_DEN_RST;
      cfg_r.abs_num   <= ABS_NUM_RST;
      cfg_r.abs_den   <= ABS_DEN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RATIO_NUM: cfg_r.ratio_num <= pwdata[CFG_W-1:0];
        REG_RATIO_DEN: cfg_r.ratio_den <= pwdata[CFG_W-1:0];
        REG_ABS_NUM:   cfg_r.abs_num   <= pwdata[CFG_W-1:0];
        REG_ABS_DEN:   cfg_r.abs_den   <= pwdata[CFG_W-1:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RATIO_NUM: prdata = APB_W'(cfg_r.ratio_num);
      REG_RATIO_DEN: prdata = APB_W'(cfg_r.ratio_den);
      REG_ABS_NUM:   prdata = APB_W'(cfg_r.abs_num);
      REG_ABS_DEN:   prdata = APB_W'(cfg_r.abs_den);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: sv/bdrm_dist.sv
`timescale 1ns / 1ps

module bdrm_dist #(
  parameter int DESC_BITS   = 256,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic                 in_valid,
  input  bdrm_pkg::in_item_t   in_data,
  output bdrm_pkg::dist_beat_t beat
);
  import bdrm_pkg::*;

  localparam int NB         = (DESC_BITS + 7) / 8;
  localparam int NBP        = 2 ** $clog2(NB);
  localparam int PAD_W      = NBP * 8;
  localparam logic [IDX_W-1:0] IDX_MASK =
    (INDEX_WIDTH >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << INDEX_WIDTH) - 64'd1);

  logic [4*WORD_W-1:0]   query_all;
  logic [4*WORD_W-1:0]   cand_all;
  logic [4*WORD_W-1:0]   diff_all;

  logic                  s1_valid_r;
  logic                  s1_last_r;
  logic [IDX_W-1:0]      s1_index_r;
  logic [DESC_BITS-1:0]  s1_diff_r;

  logic [PAD_W-1:0]      diff_pad;
  logic [DIST_W-1:0]     node [2*NBP-1];

  dist_beat_t            beat_r;

  assign query_all = {in_data.query_w3, in_data.query_w2, in_data.query_w1, in_data.query_w0};
  assign cand_all  = {in_data.cand_w3, in_data.cand_w2, in_data.cand_w1, in_data.cand_w0};
  assign diff_all  = query_all ^ cand_all;

  // Input register: differing bits of the used part of the descriptor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_last_r  <= in_data.last_cand;
      s1_index_r <= in_data.cand_index & IDX_MASK;
      s1_diff_r  <= diff_all[DESC_BITS-1:0];
    end
  end

  // Byte counts at the leaves, then a balanced adder tree.
  assign diff_pad = PAD_W'(s1_diff_r);

  for (genvar b = 0; b < NBP; b++) begin : g_leaf
    assign node[NBP-1+b] = DIST_W'(popcount8(diff_pad[b*8 +: 8]));
  end

  for (genvar i = 0; i < NBP - 1; i++) begin : g_tree
    assign node[i] = node[2*i+1] + node[2*i+2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (advance) begin
      beat_r.valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      beat_r.last     <= s1_last_r;
      beat_r.index    <= s1_index_r;
      beat_r.distance <= node[0];
    end
  end

  assign beat = beat_r;

endmodule

FILE: sv/bdrm_track.sv
`timescale 1ns / 1ps

module bdrm_track #(
  parameter int DESC_BITS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  bdrm_pkg::dist_beat_t beat,
  input  bdrm_pkg::cfg_regs_t  cfg,
  output logic                 out_valid,
  output bdrm_pkg::out_item_t  out_data
);
  import bdrm_pkg::*;

  logic [DIST_W-1:0] near_dist_r;
  logic [DIST_W-1:0] second_dist_r;
  logic [IDX_W-1:0]  best_index_r;
  logic [CNT_W-1:0]  seen_count_r;

  logic [DIST_W-1:0] near_dist_nxt;
  logic [DIST_W-1:0] second_dist_nxt;
  logic [IDX_W-1:0]  best_index_nxt;
  logic [CNT_W-1:0]  seen_count_nxt;

  logic [PROD_W-1:0] ratio_lhs;
  logic [PROD_W-1:0] ratio_rhs;
  logic [PROD_W-1:0] abs_lhs;
  logic [PROD_W-1:0] abs_rhs;
  logic              passed;

  logic              out_valid_r;
  out_item_t         out_data_r;

  // A tie with the best falls into the second branch and lowers only the second.
  always_comb begin
    near_dist_nxt   = near_dist_r;
    second_dist_nxt = second_dist_r;
    best_index_nxt  = best_index_r;
    if (beat.distance < second_dist_r) begin
      if (beat.distance < near_dist_r) begin
        second_dist_nxt = near_dist_r;
        near_dist_nxt   = beat.distance;
        best_index_nxt  = beat.index;
      end else begin
        second_dist_nxt = beat.distance;
      end
    end
    seen_count_nxt = (seen_count_r == CNT_TWO) ? CNT_TWO : seen_count_r + 2'd1;
  end

  assign ratio_lhs = PROD_W'(near_dist_nxt) * PROD_W'(cfg.ratio_den);
  assign ratio_rhs = PROD_W'(cfg.ratio_num) * PROD_W'(second_dist_nxt);
  assign abs_lhs   = PROD_W'(near_dist_nxt) * PROD_W'(cfg.abs_den);
  assign abs_rhs   = PROD_W'(cfg.abs_num) * PROD_W'(DESC_BITS);

  assign passed = (seen_count_nxt == CNT_TWO) ? (ratio_lhs < ratio_rhs)
                                              : (abs_lhs < abs_rhs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_dist_r   <= DIST_NONE;
      second_dist_r <= DIST_NONE;
      best_index_r  <= '0;
      seen_count_r  <= CNT_ZERO;
    end else if (advance && beat.valid) begin
      if (beat.last) begin
        near_dist_r   <= DIST_NONE;
        second_dist_r <= DIST_NONE;
        best_index_r  <= '0;
        seen_count_r  <= CNT_ZERO;
      end else begin
        near_dist_r   <= near_dist_nxt;
        second_dist_r <= second_dist_nxt;
        best_index_r  <= best_index_nxt;
        seen_count_r  <= seen_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= beat.valid && beat.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.matched         <= passed;
      out_data_r.best_index      <= best_index_nxt;
      out_data_r.best_distance   <= near_dist_nxt;
      out_data_r.second_distance <= second_dist_nxt;
      out_data_r.cand_count      <= seen_count_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/binary_descriptor_ratio_matcher_top.sv
`timescale 1ns / 1ps
// The last beat's result reaches out_valid through the distance and output registers.
// Throughput: one beat per cycle unless the output stalls, set by the best/second update loop.
// The three stages advance together; they halt only while a result waits on a stalled output.
// Reset (rst_n low at a clock edge) empties the pipeline, clears the best/second tracking
// and returns the configuration registers to 4/5 and 3/10.

module binary_descriptor_ratio_matcher_top #(
  parameter int DESC_BITS   = 256,
  parameter int INDEX_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  bdrm_pkg::in_item_t          in_data,

  output logic                        out_valid,
  input  logic                        out_stall,
  output bdrm_pkg::out_item_t         out_data,

  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdrm_pkg::ADDR_W-1:0] paddr,
  input  logic [bdrm_pkg::APB_W-1:0]  pwdata,
  output logic [bdrm_pkg::APB_W-1:0]  prdata,
  output logic                        pready
);
  import bdrm_pkg::*;

  cfg_regs_t  cfg;
  dist_beat_t beat;
  logic       advance;

  // The whole pipeline moves whenever the output register is empty or is being
  // taken this cycle. Beats that carry no result still pass through the output
  // stage, so the only hold-up is a finished result that the far side stalls.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  bdrm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage one registers the differing bits; stage two counts them.
  bdrm_dist #(
    .DESC_BITS   (DESC_BITS),
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .in_valid (in_valid),
    .in_data  (in_data),
    .beat     (beat)
  );

  // Stage three folds the distance into the running best and second-best,
  // and on the last candidate of a set loads the decision into the output
  // register and clears the tracking for the next query.
  bdrm_track #(
    .DESC_BITS (DESC_BITS)
  ) u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .beat      (beat),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
